// ===== design/tdpt_pkg.sv =====
// tdpt_pkg: shared types, constants and the microcode rom of the trial division prime test
// used by every module of the block; depends on nothing

package tdpt_pkg;

   // widths fixed by the transaction layout
   localparam int CANDIDATE_W      = 32;
   localparam int REQ_TDATA_W      = 32;
   localparam int RSP_TDATA_W      = 8;
   localparam int NUMBER_WIDTH_DEF = 32;

   // microcode address width and step addresses
   localparam int UADDR_W = 4;
   typedef logic [UADDR_W-1:0] tdpt_uaddr_type;

   localparam tdpt_uaddr_type STEP_IDLE      = 4'd0;
   localparam tdpt_uaddr_type STEP_CHK_LT2   = 4'd1;
   localparam tdpt_uaddr_type STEP_CHK_23    = 4'd2;
   localparam tdpt_uaddr_type STEP_CHK_EVEN  = 4'd3;
   localparam tdpt_uaddr_type STEP_DIV_GO    = 4'd4;
   localparam tdpt_uaddr_type STEP_DIV_WAIT  = 4'd5;
   localparam tdpt_uaddr_type STEP_CHK_BOUND = 4'd6;
   localparam tdpt_uaddr_type STEP_CHK_REM   = 4'd7;
   localparam tdpt_uaddr_type STEP_NEXT_D    = 4'd8;
   localparam tdpt_uaddr_type STEP_RES0      = 4'd9;
   localparam tdpt_uaddr_type STEP_DONE0     = 4'd10;
   localparam tdpt_uaddr_type STEP_RES1      = 4'd11;
   localparam tdpt_uaddr_type STEP_DONE1     = 4'd12;

   // jump conditions: when true the step jumps to its target, else falls through
   typedef enum logic [3:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_N_LT2,
      COND_N_SMALL_PRIME,
      COND_N_EVEN,
      COND_DIV_BUSY,
      COND_D_GT_Q,
      COND_REM_ZERO,
      COND_OUT_BUSY
   } tdpt_cond_type;

   // datapath actions of one step
   typedef struct packed {
      logic accept;
      logic load_d3;
      logic div_start;
      logic inc_d;
      logic put_res;
      logic res_val;
   } tdpt_act_type;

   // one control word
   typedef struct packed {
      tdpt_cond_type  cond;
      tdpt_uaddr_type target;
      tdpt_act_type   act;
   } tdpt_uword_type;

   // status flags seen by the sequencer
   typedef struct packed {
      logic req_valid;
      logic out_busy;
      logic n_lt2;
      logic n_small_prime;
      logic n_even;
      logic div_busy;
      logic d_gt_q;
      logic rem_zero;
   } tdpt_status_type;

   // microprogram
   function automatic tdpt_uword_type tdpt_rom(input tdpt_uaddr_type addr);
      tdpt_uword_type w;
      w        = '0;
      w.cond   = COND_NONE;
      w.target = STEP_IDLE;
      unique case (addr)
         STEP_IDLE: begin
            w.act.accept = 1'b1;
            w.cond       = COND_NO_REQ;
            w.target     = STEP_IDLE;
         end
         STEP_CHK_LT2: begin
            w.cond   = COND_N_LT2;
            w.target = STEP_RES0;
         end
         STEP_CHK_23: begin
            w.cond   = COND_N_SMALL_PRIME;
            w.target = STEP_RES1;
         end
         STEP_CHK_EVEN: begin
            w.act.load_d3 = 1'b1;
            w.cond        = COND_N_EVEN;
            w.target      = STEP_RES0;
         end
         STEP_DIV_GO: begin
            w.act.div_start = 1'b1;
         end
         STEP_DIV_WAIT: begin
            w.cond   = COND_DIV_BUSY;
            w.target = STEP_DIV_WAIT;
         end
         STEP_CHK_BOUND: begin
            w.cond   = COND_D_GT_Q;
            w.target = STEP_RES1;
         end
         STEP_CHK_REM: begin
            w.cond   = COND_REM_ZERO;
            w.target = STEP_RES0;
         end
         STEP_NEXT_D: begin
            w.act.inc_d = 1'b1;
            w.cond      = COND_ALWAYS;
            w.target    = STEP_DIV_GO;
         end
         STEP_RES0: begin
            w.act.put_res = 1'b1;
            w.act.res_val = 1'b0;
            w.cond        = COND_OUT_BUSY;
            w.target      = STEP_RES0;
         end
         STEP_DONE0: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         STEP_RES1: begin
            w.act.put_res = 1'b1;
            w.act.res_val = 1'b1;
            w.cond        = COND_OUT_BUSY;
            w.target      = STEP_RES1;
         end
         STEP_DONE1: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== design/tdpt_div.sv =====
// tdpt_div: restoring divider, one quotient bit per cycle, gives quotient and remainder
// depends on tdpt_pkg

module tdpt_div
   import tdpt_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUMBER_WIDTH-1:0] dividend,
   input  logic [NUMBER_WIDTH-1:0] divisor,
   output logic                    busy,
   output logic [NUMBER_WIDTH-1:0] quotient,
   output logic [NUMBER_WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(NUMBER_WIDTH + 1);

   logic                    busy_ff, busy_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [NUMBER_WIDTH-1:0] rem_ff, rem_in;
   logic [NUMBER_WIDTH-1:0] quo_ff, quo_in;
   logic [NUMBER_WIDTH-1:0] dsr_ff, dsr_in;
   logic [NUMBER_WIDTH:0]   shifted;
   logic [NUMBER_WIDTH:0]   trial;

   // one restoring step: shift in next dividend bit, try the subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[NUMBER_WIDTH-1]};
      trial   = shifted - {1'b0, dsr_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      priority if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUMBER_WIDTH);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (!trial[NUMBER_WIDTH]) begin
            rem_in = trial[NUMBER_WIDTH-1:0];
            quo_in = {quo_ff[NUMBER_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[NUMBER_WIDTH-1:0];
            quo_in = {quo_ff[NUMBER_WIDTH-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/tdpt_datapath.sv =====
// tdpt_datapath: candidate and trial divisor registers, divider and status flags
// depends on tdpt_pkg and tdpt_div

module tdpt_datapath
   import tdpt_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_n,
   input  logic [NUMBER_WIDTH-1:0] n_new,
   input  tdpt_act_type            act,
   output logic                    n_lt2,
   output logic                    n_small_prime,
   output logic                    n_even,
   output logic                    div_busy,
   output logic                    d_gt_q,
   output logic                    rem_zero
);

   logic [NUMBER_WIDTH-1:0] n_ff, n_in;
   logic [NUMBER_WIDTH-1:0] d_ff, d_in;
   logic [NUMBER_WIDTH-1:0] quotient;
   logic [NUMBER_WIDTH-1:0] remainder;

   // candidate and trial divisor
   always_comb begin
      n_in = load_n ? n_new : n_ff;
      priority if (act.load_d3) begin
         d_in = NUMBER_WIDTH'(3);
      end else if (act.inc_d) begin
         d_in = d_ff + NUMBER_WIDTH'(2);
      end else begin
         d_in = d_ff;
      end
   end

   always_ff @(posedge clock) begin
      n_ff <= n_in;
      d_ff <= d_in;
   end

   // shared divider: n / d
   tdpt_div #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (act.div_start),
      .dividend  (n_ff),
      .divisor   (d_ff),
      .busy      (div_busy),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // flags for the jump conditions
   always_comb begin
      n_lt2         = (n_ff < NUMBER_WIDTH'(2));
      n_small_prime = (n_ff == NUMBER_WIDTH'(2)) || (n_ff == NUMBER_WIDTH'(3));
      n_even        = !n_ff[0];
      d_gt_q        = (d_ff > quotient);
      rem_zero      = (remainder == '0);
   end

endmodule

// ===== design/tdpt_sequencer.sv =====
// tdpt_sequencer: step counter, microcode rom and conditional jump logic
// depends on tdpt_pkg

module tdpt_sequencer
   import tdpt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  tdpt_status_type status,
   output tdpt_uword_type  uword
);

   tdpt_uaddr_type pc_ff, pc_in;
   logic           take;

   // control word of the current step
   always_comb begin
      uword = tdpt_rom(pc_ff);
   end

   // jump condition select
   always_comb begin
      unique case (uword.cond)
         COND_NONE:          take = 1'b0;
         COND_ALWAYS:        take = 1'b1;
         COND_NO_REQ:        take = !status.req_valid;
         COND_N_LT2:         take = status.n_lt2;
         COND_N_SMALL_PRIME: take = status.n_small_prime;
         COND_N_EVEN:        take = status.n_even;
         COND_DIV_BUSY:      take = status.div_busy;
         COND_D_GT_Q:        take = status.d_gt_q;
         COND_REM_ZERO:      take = status.rem_zero;
         COND_OUT_BUSY:      take = status.out_busy;
         default:            take = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      pc_in = take ? uword.target : pc_ff + tdpt_uaddr_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== design/trial_division_prime_test_top.sv =====
// trial_division_prime_test_top: top level of the trial division prime test
// depends on tdpt_pkg, tdpt_sequencer and tdpt_datapath

// Tests one unsigned candidate per transaction and returns one bit, set when the
// candidate (taken modulo 2^NUMBER_WIDTH) is prime; zero and one are not prime.
// A microcoded sequencer drives one shared restoring divider that yields one
// quotient bit per cycle. Zero, one, two, three and even numbers are decided by
// direct checks without the divider; otherwise one division is run per odd trial
// divisor, from 3 upward, until the divisor exceeds the quotient (prime) or the
// remainder is zero (not prime). One item is worked on at a time; the result sits
// in an output register, so the next candidate is taken while an earlier result
// still waits to be read.

module trial_division_prime_test_top
   import tdpt_pkg::*;
#(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [31:0] candidate
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // [0] is_prime, [7:1] zero
);

   tdpt_uword_type  uword;
   tdpt_status_type status;
   logic            load_n;
   logic            out_busy;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_prime_ff, rsp_prime_in;
   logic [CANDIDATE_W-1:0] candidate;

   // input transaction
   assign candidate  = req_tdata[CANDIDATE_W-1:0];
   assign req_tready = uword.act.accept;
   assign load_n     = req_tvalid && uword.act.accept;

   // output slot taken and not being read
   assign out_busy = rsp_valid_ff && !rsp_tready;

   tdpt_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .uword  (uword)
   );

   tdpt_datapath #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .load_n        (load_n),
      .n_new         (NUMBER_WIDTH'(candidate)),
      .act           (uword.act),
      .n_lt2         (status.n_lt2),
      .n_small_prime (status.n_small_prime),
      .n_even        (status.n_even),
      .div_busy      (status.div_busy),
      .d_gt_q        (status.d_gt_q),
      .rem_zero      (status.rem_zero)
   );

   assign status.req_valid = req_tvalid;
   assign status.out_busy  = out_busy;

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_prime_in = rsp_prime_ff;
      if (uword.act.put_res && !out_busy) begin
         rsp_valid_in = 1'b1;
         rsp_prime_in = uword.act.res_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_prime_ff <= rsp_prime_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - 1)'(0), rsp_prime_ff};

endmodule

// ===== design/tdpt_checker.sv =====
// tdpt_checker: port-level assertions for the trial division prime test, bound to the top
// depends on tdpt_pkg and trial_division_prime_test_top

module tdpt_checker
   import tdpt_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // an accepted candidate keeps the block busy for at least the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("new candidate taken straight after an accept");

   // after reset the block is ready and holds no result
   assert property (@(posedge clock)
      $past(reset) && !reset |-> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

   // an accepted candidate cannot produce a result in the very next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared without any work");

   // padding bits of the result stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:1] == '0)
      else $error("result padding not zero");

endmodule

bind trial_division_prime_test_top tdpt_checker u_tdpt_checker (.*);

// ===== dv/tb.sv =====
// tb: self-checking testbench for trial_division_prime_test_top
// depends on tdpt_pkg and the design files under design/

module tb;
   import tdpt_pkg::*;

   localparam int NUM_W        = NUMBER_WIDTH_DEF;
   localparam int GAP_PCT      = 33;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 100000;
   localparam int DRAIN_CYCLES = 20;

   typedef logic [CANDIDATE_W-1:0] candidate_type;

   typedef struct {
      candidate_type cand;
      bit            is_prime;
   } verdict_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // [31:0] candidate
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // [0] is_prime, [7:1] zero

   // verdicts still owed by the block, oldest first
   verdict_type expected_verdicts[$];
   verdict_type oldest;
   int          error_count = 0;

   // flow control shared between the stimulus and the receiver
   bit       gaps_on    = 1'b1;
   bit       hold_token = 1'b0;
   bit       hold_seen  = 1'b0;
   int       hold_left  = 0;

   trial_division_prime_test_top #(
      .NUMBER_WIDTH(NUM_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // primality by trial division over odd divisors, bound kept overflow free
   function automatic bit predict_primality(input candidate_type cand);
      longint unsigned n;
      longint unsigned d;
      longint unsigned mask;
      mask = (NUM_W >= 64) ? '1 : ((64'd1 << NUM_W) - 64'd1);
      n    = cand;
      n    = n & mask;
      if (n < 2) return 1'b0;
      if (n == 2 || n == 3) return 1'b1;
      if (n[0] == 1'b0) return 1'b0;
      for (d = 3; d <= n / d; d += 2) begin
         if (n % d == 0) return 1'b0;
      end
      return 1'b1;
   endfunction

   // mostly cheap candidates: small, mid-sized, or full width with a small factor
   function automatic candidate_type random_candidate();
      int unsigned   pick;
      int unsigned   factor;
      candidate_type v;
      pick = $urandom_range(99);
      if (pick < 35) begin
         v = $urandom_range(4095);
      end else if (pick < 60) begin
         v = $urandom_range(32'h0010_0000, 4096);
      end else begin
         factor = $urandom_range(13, 2);
         v      = $urandom;
         v      = v - (v % factor);
      end
      return v;
   endfunction

   // offer one candidate, record its verdict once the transaction is taken
   task automatic send_candidate(input candidate_type value);
      while (gaps_on && $urandom_range(99) < GAP_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_verdicts.push_back('{cand: value, is_prime: predict_primality(value)});
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
   endtask

   // zero, one, two, three, even numbers, prime squares and the width extremes
   task automatic test_directed_cases();
      candidate_type corner_cases[19] = '{
         32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd15, 32'd25, 32'd35,
         32'd121, 32'd63001, 32'd65521, 32'd65537, 32'd1022117,
         32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFE, 32'hFFFF_FFFF
      };
      gaps_on = 1'b1;
      foreach (corner_cases[i]) send_candidate(corner_cases[i]);
      wait_drained();
   endtask

   // back to back transactions on both sides
   task automatic test_unbroken_stream();
      gaps_on = 1'b0;
      repeat (20) send_candidate(random_candidate());
      wait_drained();
      gaps_on = 1'b1;
   endtask

   // receiver holds off while cheap candidates keep coming, so the input stalls
   task automatic test_output_stall();
      hold_token <= ~hold_token;
      repeat (10) send_candidate($urandom_range(64));
      wait_drained();
   endtask

   task automatic test_random_mix();
      gaps_on = 1'b1;
      repeat (50) send_candidate(random_candidate());
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_unbroken_stream();
      test_output_stall();
      test_random_mix();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_verdicts.size() != 0) begin
         $error("%0d verdicts never returned", expected_verdicts.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // receiver: check each result transaction, then choose the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               $error("result transaction with no candidate outstanding: is_prime %0b",
                      rsp_tdata[0]);
               error_count++;
            end else begin
               oldest = expected_verdicts.pop_front();
               if (rsp_tdata[0] !== oldest.is_prime) begin
                  $error("is_prime for candidate %0d: expected %0b, actual %0b",
                         oldest.cand, oldest.is_prime, rsp_tdata[0]);
                  error_count++;
               end
               if (rsp_tdata[RSP_TDATA_W-1:1] !== '0) begin
                  $error("rsp_tdata pad for candidate %0d: expected 0, actual %0h",
                         oldest.cand, rsp_tdata[RSP_TDATA_W-1:1]);
                  error_count++;
               end
            end
         end
         if (hold_token != hold_seen) begin
            hold_seen  <= hold_token;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !gaps_on || ($urandom_range(99) >= GAP_PCT);
         end
      end
   end

   // watchdog: too long without any transaction on either side
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/tdpt_pkg.sv
design/tdpt_div.sv
design/tdpt_datapath.sv
design/tdpt_sequencer.sv
design/trial_division_prime_test_top.sv
design/tdpt_checker.sv
dv/tb.sv
